>>> src/vertex_affine_transform_core_macros.svh
// Assertion macros for the vertex affine transform core.
`ifndef VERTEX_AFFINE_TRANSFORM_CORE_MACROS_SVH
`define VERTEX_AFFINE_TRANSFORM_CORE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define VAT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define VAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/vat_pkg.sv
// Shared types, constants and tables of the vertex affine transform core.
package vat_pkg;

  localparam int COORD_BITS        = 32;
  localparam int FRAC_BITS_DEF     = 16;
  localparam int ANGLE_BITS_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam int GUARD_BITS  = 8;
  // Guard bits, quadrant negation and CORDIC growth need three more bits.
  localparam int CORDIC_BITS = COORD_BITS + GUARD_BITS + 3;
  localparam int ZACC_BITS   = 32;
  localparam int GAIN_SHIFT  = 30;
  localparam int ROT_SHIFT   = GAIN_SHIFT + GUARD_BITS;
  localparam int FACTOR_BITS = (COORD_BITS - 1 > GAIN_SHIFT) ? COORD_BITS - 1 : GAIN_SHIFT;
  localparam logic [FACTOR_BITS-1:0] GAIN_Q30 = FACTOR_BITS'(652032874);
  localparam int MUL_LAT     = 5;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_OP_MODE      = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SHIFT_AMOUNT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_TURN_ANGLE   = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCALE_RATIO  = 2'd3;

  localparam logic [2:0] MODE_SHIFT_X = 3'd0;
  localparam logic [2:0] MODE_SHIFT_Y = 3'd1;
  localparam logic [2:0] MODE_SHIFT_Z = 3'd2;
  localparam logic [2:0] MODE_ROT_X   = 3'd3;
  localparam logic [2:0] MODE_ROT_Y   = 3'd4;
  localparam logic [2:0] MODE_ROT_Z   = 3'd5;
  localparam logic [2:0] MODE_SCALE   = 3'd6;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;
    logic                         last_vertex;
  } vertex_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic signed [COORD_BITS-1:0] out_z;
    logic                         out_last;
  } result_t;

  // One beat as it travels down the CORDIC chain.
  typedef struct packed {
    logic                          valid;
    logic                          last;
    logic                          rot;
    logic signed [CORDIC_BITS-1:0] a;
    logic signed [CORDIC_BITS-1:0] b;
    logic signed [COORD_BITS-1:0]  c;
    logic signed [ZACC_BITS-1:0]   z;
  } cordic_t;

  typedef struct packed {
    logic use_mul;
    logic rot;
  } mul_ctrl_t;

  // Arctangent of 2^-i in units of 2^32 per turn.
  function automatic logic [ZACC_BITS-1:0] atan_turn(input logic [4:0] idx);
    logic [ZACC_BITS-1:0] val;
    case (idx)
      5'd0:    val = 32'd536870912;
      5'd1:    val = 32'd316933406;
      5'd2:    val = 32'd167458907;
      5'd3:    val = 32'd85004756;
      5'd4:    val = 32'd42667331;
      5'd5:    val = 32'd21354465;
      5'd6:    val = 32'd10679838;
      5'd7:    val = 32'd5340245;
      5'd8:    val = 32'd2670163;
      5'd9:    val = 32'd1335087;
      5'd10:   val = 32'd667544;
      5'd11:   val = 32'd333772;
      5'd12:   val = 32'd166886;
      5'd13:   val = 32'd83443;
      5'd14:   val = 32'd41722;
      5'd15:   val = 32'd20861;
      5'd16:   val = 32'd10430;
      5'd17:   val = 32'd5215;
      5'd18:   val = 32'd2608;
      5'd19:   val = 32'd1304;
      5'd20:   val = 32'd652;
      5'd21:   val = 32'd326;
      5'd22:   val = 32'd163;
      5'd23:   val = 32'd81;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

>>> src/vat_cordic_cell.sv
// One CORDIC rotation cell of the chain, registered at its output.
module vat_cordic_cell #(
  parameter int STAGE_IDX = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vat_pkg::cordic_t  d_i,
  output vat_pkg::cordic_t  q_o
);
  import vat_pkg::*;

  localparam logic signed [ZACC_BITS-1:0] ATAN = $signed(atan_turn(5'(STAGE_IDX)));

  cordic_t                       cell_d, cell_q;
  logic signed [CORDIC_BITS-1:0] da, db;

  always_comb begin
    cell_d = d_i;
    da     = $signed(d_i.b) >>> STAGE_IDX;
    db     = $signed(d_i.a) >>> STAGE_IDX;
    if (d_i.rot) begin
      // Rotate toward zero residual angle.
      if (!d_i.z[ZACC_BITS-1]) begin
        cell_d.a = d_i.a - da;
        cell_d.b = d_i.b + db;
        cell_d.z = d_i.z - ATAN;
      end else begin
        cell_d.a = d_i.a + da;
        cell_d.b = d_i.b - db;
        cell_d.z = d_i.z + ATAN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign q_o = cell_q;

endmodule

>>> src/vat_mul_lane.sv
// Pipelined sign-magnitude multiply with rounding, shift and saturation for one lane.
module vat_mul_lane #(
  parameter int FRAC_BITS = vat_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic signed [vat_pkg::CORDIC_BITS-1:0]  op_i,
  input  logic        [vat_pkg::FACTOR_BITS-1:0]  factor_i,
  input  vat_pkg::mul_ctrl_t                      ctrl_i,
  output logic signed [vat_pkg::COORD_BITS-1:0]   res_o
);
  import vat_pkg::*;

  localparam int CW = CORDIC_BITS;
  localparam int AL = (CW + 1) / 2;
  localparam int AH = CW - AL;
  localparam int FL = (FACTOR_BITS + 1) / 2;
  localparam int FH = FACTOR_BITS - FL;
  localparam int PW = CW + FACTOR_BITS;

  localparam logic [PW-1:0] HALF = PW'(1) << (COORD_BITS - 1);
  localparam logic [PW-1:0] RND_ROT = PW'(1) << (ROT_SHIFT - 1);
  localparam logic [PW-1:0] RND_FRAC = PW'(1) << (FRAC_BITS - 1);
  localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  // Stage 0: magnitude and sign.
  logic [CW-1:0]          mag_q;
  logic [FACTOR_BITS-1:0] fac_q;
  logic [COORD_BITS-1:0]  pass0_q, pass1_q, pass2_q, pass3_q;
  logic                   neg0_q, neg1_q, neg2_q, neg3_q;
  mul_ctrl_t              ctrl0_q, ctrl1_q, ctrl2_q, ctrl3_q;

  // Stage 1: partial products.
  logic [AL+FL-1:0] p_ll_q;
  logic [AL+FH-1:0] p_lh_q;
  logic [AH+FL-1:0] p_hl_q;
  logic [AH+FH-1:0] p_hh_q;

  // Stages 2 and 3: partial sums and total.
  logic [PW-1:0] s1_q, s2_q, tot_q;
  logic [PW-1:0] rnd, quo;
  logic [COORD_BITS-1:0] qlo;
  logic signed [COORD_BITS-1:0] res_d, res_q;

  assign rnd = ctrl1_q.rot ? RND_ROT : RND_FRAC;

  always_ff @(posedge clk_i) begin
    mag_q   <= op_i[CW-1] ? CW'(-op_i) : CW'(op_i);
    neg0_q  <= op_i[CW-1];
    fac_q   <= factor_i;
    pass0_q <= op_i[COORD_BITS-1:0];
    ctrl0_q <= ctrl_i;

    p_ll_q  <= (AL+FL)'(mag_q[AL-1:0]) * (AL+FL)'(fac_q[FL-1:0]);
    p_lh_q  <= (AL+FH)'(mag_q[AL-1:0]) * (AL+FH)'(fac_q[FACTOR_BITS-1:FL]);
    p_hl_q  <= (AH+FL)'(mag_q[CW-1:AL]) * (AH+FL)'(fac_q[FL-1:0]);
    p_hh_q  <= (AH+FH)'(mag_q[CW-1:AL]) * (AH+FH)'(fac_q[FACTOR_BITS-1:FL]);
    neg1_q  <= neg0_q;
    pass1_q <= pass0_q;
    ctrl1_q <= ctrl0_q;

    s1_q    <= PW'(p_ll_q) + (PW'(p_lh_q) << FL) + rnd;
    s2_q    <= PW'(p_hl_q) + (PW'(p_hh_q) << FL);
    neg2_q  <= neg1_q;
    pass2_q <= pass1_q;
    ctrl2_q <= ctrl1_q;

    tot_q   <= s1_q + (s2_q << AL);
    neg3_q  <= neg2_q;
    pass3_q <= pass2_q;
    ctrl3_q <= ctrl2_q;

    res_q   <= res_d;
  end

  always_comb begin
    quo = ctrl3_q.rot ? (tot_q >> ROT_SHIFT) : (tot_q >> FRAC_BITS);
    qlo = quo[COORD_BITS-1:0];
    if (!ctrl3_q.use_mul) begin
      res_d = $signed(pass3_q);
    end else if (neg3_q) begin
      res_d = (quo > HALF) ? CMIN : $signed(COORD_BITS'(0) - qlo);
    end else begin
      res_d = (quo > HALF - PW'(1)) ? CMAX : $signed(qlo);
    end
  end

  assign res_o = res_q;

endmodule

>>> src/vertex_affine_transform_core.sv
// Top level of the vertex affine transform core: config registers, entry stage, CORDIC chain
// and output multipliers.
//
// The core takes one vertex per clock: busy is always low, so every cycle with start high
// moves a beat in. Each beat comes out on result_o with done_o high for exactly one cycle,
// in the order the vertices went in. The receiver has no way to stall the core and must take
// every result beat in the cycle it appears. Each beat passes the entry stage, one register
// per CORDIC cell, the five-stage rounding multiplier and the output register; every mode
// goes down the same path, so latency does not depend on the mode. The four registers are
// written over the plain write port and must only change while no vertex is in flight, since
// the entry stage, the multiplier inputs and the output register read them directly.
`include "vertex_affine_transform_core_macros.svh"

module vertex_affine_transform_core #(
  parameter int FRAC_BITS     = vat_pkg::FRAC_BITS_DEF,
  parameter int ANGLE_BITS    = vat_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = vat_pkg::CORDIC_STAGES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  vat_pkg::vertex_t                   vertex_i,
  output logic                               done_o,
  output vat_pkg::result_t                   result_o,
  input  logic                               cfg_we_i,
  input  logic [vat_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [vat_pkg::COORD_BITS-1:0]     cfg_data_i
);
  import vat_pkg::*;

  localparam int CW        = CORDIC_BITS;
  localparam int TOTAL_LAT = CORDIC_STAGES + MUL_LAT + 2;

  // Quarter-turn codes taken from the top two bits of the angle.
  localparam logic [1:0] QUAD_90  = 2'd1;
  localparam logic [1:0] QUAD_180 = 2'd2;
  localparam logic [1:0] QUAD_270 = 2'd3;

  // Configuration registers.
  logic [2:0]                   op_mode_q;
  logic signed [COORD_BITS-1:0] shift_amount_q;
  logic [ANGLE_BITS-1:0]        turn_angle_q;
  logic signed [COORD_BITS-1:0] scale_ratio_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_mode_q      <= MODE_SHIFT_X;
      shift_amount_q <= '0;
      turn_angle_q   <= '0;
      scale_ratio_q  <= COORD_BITS'(1) << FRAC_BITS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_OP_MODE:      op_mode_q      <= cfg_data_i[2:0];
        REG_SHIFT_AMOUNT: shift_amount_q <= $signed(cfg_data_i);
        REG_TURN_ANGLE:   turn_angle_q   <= cfg_data_i[ANGLE_BITS-1:0];
        REG_SCALE_RATIO:  scale_ratio_q  <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // The pipeline never pushes back.
  assign busy = 1'b0;

  // Saturating add used by the shift modes.
  function automatic logic signed [COORD_BITS-1:0] sat_add(
    input logic signed [COORD_BITS-1:0] lhs,
    input logic signed [COORD_BITS-1:0] rhs
  );
    logic signed [COORD_BITS:0]   sum;
    logic signed [COORD_BITS-1:0] res;
    sum = COORD_BITS'(0) + {lhs[COORD_BITS-1], lhs} + {rhs[COORD_BITS-1], rhs};
    if (sum[COORD_BITS] != sum[COORD_BITS-1]) begin
      res = sum[COORD_BITS] ? {1'b1, {(COORD_BITS-1){1'b0}}} : {1'b0, {(COORD_BITS-1){1'b1}}};
    end else begin
      res = sum[COORD_BITS-1:0];
    end
    return res;
  endfunction

  // Entry stage: shift modes finish here; rotation modes pick their coordinate pair, add the
  // guard bits and do the exact quarter-turn pre-rotation.
  logic [ZACC_BITS-1:0]         ang;
  logic signed [COORD_BITS-1:0] px, py, pz, pa, pb;
  logic signed [CW-1:0]         ga, gb;
  cordic_t                      entry_d, entry_q;

  always_comb begin
    px  = vertex_i.coord_x;
    py  = vertex_i.coord_y;
    pz  = vertex_i.coord_z;
    ang = {turn_angle_q, {(ZACC_BITS-ANGLE_BITS){1'b0}}};
    pa  = px;
    pb  = py;

    entry_d.valid = start && !busy;
    entry_d.last  = vertex_i.last_vertex;
    entry_d.rot   = 1'b0;
    entry_d.a     = CW'(px);
    entry_d.b     = CW'(py);
    entry_d.c     = pz;
    entry_d.z     = $signed({2'b00, ang[ZACC_BITS-3:0]});

    case (op_mode_q)
      MODE_SHIFT_X: entry_d.a = CW'(sat_add(px, shift_amount_q));
      MODE_SHIFT_Y: entry_d.b = CW'(sat_add(py, shift_amount_q));
      MODE_SHIFT_Z: entry_d.c = sat_add(pz, shift_amount_q);
      MODE_ROT_X: begin
        pa = py;
        pb = pz;
        entry_d.c   = px;
        entry_d.rot = 1'b1;
      end
      MODE_ROT_Y: begin
        pa = pz;
        pb = px;
        entry_d.c   = py;
        entry_d.rot = 1'b1;
      end
      MODE_ROT_Z: begin
        entry_d.rot = 1'b1;
      end
      default: ;
    endcase

    ga = CW'(pa) <<< GUARD_BITS;
    gb = CW'(pb) <<< GUARD_BITS;
    if (entry_d.rot) begin
      case (ang[ZACC_BITS-1:ZACC_BITS-2])
        QUAD_90: begin
          entry_d.a = -gb;
          entry_d.b = ga;
        end
        QUAD_180: begin
          entry_d.a = -ga;
          entry_d.b = -gb;
        end
        QUAD_270: begin
          entry_d.a = gb;
          entry_d.b = -ga;
        end
        default: begin
          entry_d.a = ga;
          entry_d.b = gb;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  // CORDIC chain: one cell per iteration. Beats that do not rotate pass through unchanged.
  cordic_t chain [CORDIC_STAGES+1];
  assign chain[0] = entry_q;

  for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_cell
    vat_cordic_cell #(
      .STAGE_IDX (gi)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .d_i    (chain[gi]),
      .q_o    (chain[gi+1])
    );
  end

  // Output multipliers: rotated pairs take the CORDIC gain, scale mode with a positive ratio
  // takes the ratio on all three lanes, and everything else passes straight through.
  cordic_t                      tail;
  logic                         scale_on;
  mul_ctrl_t                    ctrl_ab, ctrl_c;
  logic [FACTOR_BITS-1:0]       factor_ab, factor_c;
  logic signed [COORD_BITS-1:0] res_a, res_b, res_c;

  assign tail      = chain[CORDIC_STAGES];
  assign scale_on  = (op_mode_q == MODE_SCALE) && (scale_ratio_q > 0);
  assign ctrl_ab   = '{use_mul: tail.rot || scale_on, rot: tail.rot};
  assign ctrl_c    = '{use_mul: scale_on, rot: 1'b0};
  assign factor_ab = tail.rot ? GAIN_Q30 : FACTOR_BITS'(scale_ratio_q);
  assign factor_c  = FACTOR_BITS'(scale_ratio_q);

  vat_mul_lane #(.FRAC_BITS (FRAC_BITS)) u_lane_a (
    .clk_i    (clk_i),
    .op_i     (tail.a),
    .factor_i (factor_ab),
    .ctrl_i   (ctrl_ab),
    .res_o    (res_a)
  );

  vat_mul_lane #(.FRAC_BITS (FRAC_BITS)) u_lane_b (
    .clk_i    (clk_i),
    .op_i     (tail.b),
    .factor_i (factor_ab),
    .ctrl_i   (ctrl_ab),
    .res_o    (res_b)
  );

  vat_mul_lane #(.FRAC_BITS (FRAC_BITS)) u_lane_c (
    .clk_i    (clk_i),
    .op_i     (CW'(tail.c)),
    .factor_i (factor_c),
    .ctrl_i   (ctrl_c),
    .res_o    (res_c)
  );

  // Beat valid and last flag follow the multiplier latency.
  logic [MUL_LAT-1:0] vld_q, lst_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      lst_q <= '0;
    end else begin
      vld_q <= {vld_q[MUL_LAT-2:0], tail.valid};
      lst_q <= {lst_q[MUL_LAT-2:0], tail.last};
    end
  end

  // Output register: lanes go back to x, y and z according to the mode.
  logic    done_q;
  result_t result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[MUL_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    result_q.out_last <= lst_q[MUL_LAT-1];
    case (op_mode_q)
      MODE_ROT_X: begin
        result_q.out_x <= res_c;
        result_q.out_y <= res_a;
        result_q.out_z <= res_b;
      end
      MODE_ROT_Y: begin
        result_q.out_x <= res_b;
        result_q.out_y <= res_c;
        result_q.out_z <= res_a;
      end
      default: begin
        result_q.out_x <= res_a;
        result_q.out_y <= res_b;
        result_q.out_z <= res_c;
      end
    endcase
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  // Every accepted beat leaves after the fixed latency, and no result appears on its own.
  `VAT_ASSERT(a_lat_fixed, (start && !busy) |-> ##(TOTAL_LAT) done_o, "result beat missing")
  `VAT_ASSERT(a_no_spurious, done_o |-> $past(start, TOTAL_LAT), "unexpected result beat")
  `VAT_ASSERT(a_last_follows,
    done_o |-> (result_o.out_last == $past(vertex_i.last_vertex, TOTAL_LAT)),
    "last flag out of step")
  `VAT_ASSERT_NEXT(a_busy_low, 1'b1, !busy, "core pushed back")

endmodule
